@@ rtl/core/grp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grp_pkg - shared types and constants of the guillotine rectangle packer
// Node record, opcodes, result codes, register indexes and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package grp_pkg;

   localparam int MAX_NODES = 256;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int COORD_W   = 12;

   localparam logic [COORD_W-1:0] ATLAS_RESET = COORD_W'(700);

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] wide;
      logic [COORD_W-1:0] tall;
   } node_type;

   localparam node_type RESET_NODE = '{
      left: '0, top: '0, wide: ATLAS_RESET, tall: ATLAS_RESET
   };

   typedef enum logic {
      OP_PLACE = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_PLACED  = 2'd0,
      ST_NO_FIT  = 2'd1,
      ST_FULL    = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   typedef enum logic {
      CSR_ATLAS_WIDTH  = 1'b0,
      CSR_ATLAS_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SWAP,
      S_APPEND_A,
      S_APPEND_B
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;   // latch request, read newest node
      logic clear;  // reseed the store, answer cleared
      logic full;   // answer store full
      logic step;   // read next older node
      logic hit;    // latch fitting node
      logic nofit;  // answer no fit
      logic swap;   // move last node into the used slot
      logic app_a;  // append full-span piece on the larger leftover side
      logic app_b;  // append the other piece, answer placed
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic store_full;
      logic fit;
      logic scan_last;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ rtl/core/guillotine_rect_packer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// guillotine_rect_packer - guillotine rectangle packer for a 2D atlas
// Keeps up to MAX_NODES free nodes and answers place and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_* and raise start; the transfer happens at the edge
//   where start is high and busy is low. Opcode 0 places a rectangle,
//   opcode 1 reseeds the store with one node of csr atlas size.
//   Result: one per request, on rsp_* for exactly one cycle with rsp_valid
//   high. The receiver cannot stall; the result is gone after that cycle.
//   Timing: clear and store-full requests answer in the cycle after the
//   transfer and leave busy low. A place request scans the free nodes
//   newest first, one node per cycle through the node memory's registered
//   read port; when it places, busy also covers the swap and two appends
//   (which share the single write port). The result appears in the cycle
//   after the last busy one. Worst case is a scan of MAX_NODES - 1 nodes
//   plus the write-back.
//   csr_write with csr_index 0/1 sets atlas width/height; it takes effect
//   at the next clear. Write only while idle.
//   Reset: atlas 700 x 700, one free node covering it, no memory sweep.
// ----------------------------------------------------------------------------
module guillotine_rect_packer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_opcode,
   input  wire logic [grp_pkg::COORD_W-1:0] req_rect_width,
   input  wire logic [grp_pkg::COORD_W-1:0] req_rect_height,
   input  wire logic                        csr_write,
   input  wire logic                        csr_index,
   input  wire logic [grp_pkg::COORD_W-1:0] csr_wdata,
   output logic                             rsp_valid,
   output logic                             rsp_placed,
   output logic [grp_pkg::COORD_W-1:0]      rsp_pos_x,
   output logic [grp_pkg::COORD_W-1:0]      rsp_pos_y,
   output logic [1:0]                       rsp_status
);
   import grp_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   grp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   grp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_placed      (rsp_placed),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_status      (rsp_status)
   );

endmodule
`default_nettype wire

@@ rtl/core/grp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grp_ctrl - packer sequencer
// Accepts requests, walks the node scan and orders the write-back of a
// placement: swap-remove, then two appends.
// ----------------------------------------------------------------------------
module grp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_opcode,
   input  wire grp_pkg::dp_stat_type stat,
   output grp_pkg::cmd_type          cmd,
   output logic                      busy
);
   import grp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_opcode == OP_CLEAR) begin
                  cmd.clear = 1'b1;
               end else if (stat.store_full) begin
                  cmd.full = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (stat.fit) begin
               cmd.hit  = 1'b1;
               state_in = S_SWAP;
            end else if (stat.scan_last) begin
               cmd.nofit = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_SWAP: begin
            cmd.swap = 1'b1;
            state_in = S_APPEND_A;
         end
         S_APPEND_A: begin
            cmd.app_a = 1'b1;
            state_in  = S_APPEND_B;
         end
         S_APPEND_B: begin
            cmd.app_b = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_write_back_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWAP |=> state_ff == S_APPEND_A ##1 state_ff == S_APPEND_B)
      else $error("write-back sequence broken");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load || cmd.clear || cmd.full) |-> state_ff == S_IDLE)
      else $error("request taken while busy");

   a_hit_to_swap: assert property (@(posedge clock) disable iff (reset)
      cmd.hit |=> state_ff == S_SWAP)
      else $error("hit did not start write-back");

endmodule
`default_nettype wire

@@ rtl/core/grp_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grp_datapath - node store, scan compare, split and result registers
// Holds the free-node memory (one write, one registered read per cycle),
// the node count, the atlas registers and the result strobe.
// ----------------------------------------------------------------------------
module grp_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire grp_pkg::cmd_type            cmd,
   output grp_pkg::dp_stat_type             stat,
   input  wire logic [grp_pkg::COORD_W-1:0] req_rect_width,
   input  wire logic [grp_pkg::COORD_W-1:0] req_rect_height,
   input  wire logic                        csr_write,
   input  wire logic                        csr_index,
   input  wire logic [grp_pkg::COORD_W-1:0] csr_wdata,
   output logic                             rsp_valid,
   output logic                             rsp_placed,
   output logic [grp_pkg::COORD_W-1:0]      rsp_pos_x,
   output logic [grp_pkg::COORD_W-1:0]      rsp_pos_y,
   output logic [1:0]                       rsp_status
);
   import grp_pkg::*;

   node_type mem [MAX_NODES];
   node_type rd_q_ff;
   logic     rd_default_ff;
   logic     entry0_valid_ff;

   logic [COORD_W-1:0] atlas_w_ff, atlas_w_in;
   logic [COORD_W-1:0] atlas_h_ff, atlas_h_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               first_ff, first_in;
   logic [COORD_W-1:0] rect_w_ff, rect_w_in;
   logic [COORD_W-1:0] rect_h_ff, rect_h_in;
   node_type           last_ff, last_in;
   node_type           hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_placed_ff, rsp_placed_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic               rd_en, wr_en;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   node_type           wr_data, rd_node, piece_a, piece_b;
   logic [CNT_W-1:0]   count_m1;
   logic [COORD_W-1:0] rem_w, rem_h;

   assign count_m1 = count_ff - CNT_W'(1);
   assign rd_node  = rd_default_ff ? RESET_NODE : rd_q_ff;

   assign stat.store_full = (count_ff == CNT_W'(MAX_NODES));
   assign stat.fit        = (rd_node.wide > rect_w_ff) && (rd_node.tall > rect_h_ff);
   assign stat.scan_last  = (cmp_idx_ff == '0);

   // split along the larger leftover side
   assign rem_w = hit_ff.wide - rect_w_ff;
   assign rem_h = hit_ff.tall - rect_h_ff;

   always_comb begin
      if (rem_h > rem_w) begin
         piece_a = '{left: hit_ff.left, top: hit_ff.top + rect_h_ff,
                     wide: hit_ff.wide, tall: rem_h};
         piece_b = '{left: hit_ff.left + rect_w_ff, top: hit_ff.top,
                     wide: rem_w, tall: rect_h_ff};
      end else begin
         piece_a = '{left: hit_ff.left + rect_w_ff, top: hit_ff.top,
                     wide: rem_w, tall: hit_ff.tall};
         piece_b = '{left: hit_ff.left, top: hit_ff.top + rect_h_ff,
                     wide: rect_w_ff, tall: rem_h};
      end
   end

   // memory ports
   always_comb begin
      rd_en   = cmd.load || cmd.step;
      rd_addr = cmd.load ? count_m1[IDX_W-1:0] : cmp_idx_ff - IDX_W'(1);
      wr_en   = cmd.clear || cmd.swap || cmd.app_a || cmd.app_b;
      wr_addr = '0;
      wr_data = '{left: '0, top: '0, wide: atlas_w_ff, tall: atlas_h_ff};
      if (cmd.swap) begin
         wr_addr = hit_idx_ff;
         wr_data = last_ff;
      end else if (cmd.app_a) begin
         wr_addr = count_m1[IDX_W-1:0];
         wr_data = piece_a;
      end else if (cmd.app_b) begin
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = piece_b;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff       <= mem[rd_addr];
         rd_default_ff <= (rd_addr == '0) && !entry0_valid_ff;
      end
   end

   always_comb begin
      atlas_w_in    = atlas_w_ff;
      atlas_h_in    = atlas_h_ff;
      count_in      = count_ff;
      cmp_idx_in    = cmp_idx_ff;
      first_in      = cmd.load;
      rect_w_in     = rect_w_ff;
      rect_h_in     = rect_h_ff;
      last_in       = first_ff ? rd_node : last_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_placed_in = 1'b0;
      rsp_x_in      = '0;
      rsp_y_in      = '0;
      rsp_status_in = rsp_status_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_ATLAS_WIDTH:  atlas_w_in = csr_wdata;
            CSR_ATLAS_HEIGHT: atlas_h_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         rect_w_in  = req_rect_width;
         rect_h_in  = req_rect_height;
         cmp_idx_in = count_m1[IDX_W-1:0];
      end
      if (cmd.step) begin
         cmp_idx_in = cmp_idx_ff - IDX_W'(1);
      end
      if (cmd.hit) begin
         hit_in     = rd_node;
         hit_idx_in = cmp_idx_ff;
      end
      if (cmd.clear) begin
         count_in      = CNT_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_CLEARED;
      end
      if (cmd.full) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_FULL;
      end
      if (cmd.nofit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_NO_FIT;
      end
      if (cmd.app_b) begin
         // net effect of one removal and two appends
         count_in      = count_ff + CNT_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_placed_in = 1'b1;
         rsp_x_in      = hit_ff.left;
         rsp_y_in      = hit_ff.top;
         rsp_status_in = ST_PLACED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_w_ff      <= ATLAS_RESET;
         atlas_h_ff      <= ATLAS_RESET;
         count_ff        <= CNT_W'(1);
         first_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         entry0_valid_ff <= 1'b0;
      end else begin
         atlas_w_ff   <= atlas_w_in;
         atlas_h_ff   <= atlas_h_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en && (wr_addr == '0)) begin
            entry0_valid_ff <= 1'b1;
         end
      end
      cmp_idx_ff    <= cmp_idx_in;
      rect_w_ff     <= rect_w_in;
      rect_h_ff     <= rect_h_in;
      last_ff       <= last_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_placed = rsp_placed_ff;
   assign rsp_pos_x  = rsp_x_ff;
   assign rsp_pos_y  = rsp_y_ff;
   assign rsp_status = rsp_status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CNT_W'(MAX_NODES))
      else $error("node count out of range");

   a_placed_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_placed_ff == (rsp_status_ff == ST_PLACED)))
      else $error("placed flag disagrees with status");

   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_placed_ff) |-> (rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("position not zero on a failed placement");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.swap, cmd.app_a, cmd.app_b}))
      else $error("two memory writes in one cycle");

endmodule
`default_nettype wire
